/* design/kmsd_pkg.sv */
// Shared types and constants for the key matrix scanner with global debounce.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package kmsd_pkg;

	// Default matrix geometry.
	localparam int ROWS_DEF = 8;
	localparam int COLS_DEF = 16;

	// Debounce setting and counter width, and the key count field.
	localparam int CNT_W   = 8;
	localparam int KEY_W   = 8;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;
	localparam logic [CNT_W-1:0] PASSES_RESET = CNT_W'(1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the incoming column word
		logic update;     // compare with raw row, reload or step the counter
		logic copy_step;  // copy one raw row to the stable matrix and count it
		logic emit;       // load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic copy_needed;  // the counter reaches zero at this pass end
		logic sweep_last;   // the copy sweep is at its last row
		logic out_free;     // the result register can take a new word
	} sts_t;

endpackage

`default_nettype wire

/* design/kmsd_ctrl.sv */
// Controller state machine for the key matrix scanner.
// Sequences capture, row update, the stable copy sweep and result emission; uses kmsd_pkg.
`default_nettype none

module kmsd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  kmsd_pkg::sts_t sts,
	output kmsd_pkg::cmd_t cmd
);
	import kmsd_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_UPDATE = 2'd1;
	localparam logic [1:0] ST_COPY   = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = sts.copy_needed ? ST_COPY : ST_EMIT;
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// Wait here only while the previous result is still unclaimed.
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

/* design/kmsd_datapath.sv */
// Datapath of the key matrix scanner: raw and stable row stores, debounce counter,
// row pointer, key total accumulator and the result register; uses kmsd_pkg.
`default_nettype none

module kmsd_datapath #(
	parameter int ROWS = kmsd_pkg::ROWS_DEF,
	parameter int COLS = kmsd_pkg::COLS_DEF,
	parameter int RW   = (ROWS > 1) ? $clog2(ROWS) : 1,
	parameter int OUT_W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [COLS-1:0]          column_bits,
	input  logic                     cfg_valid,
	input  logic [kmsd_pkg::CNT_W-1:0] cfg_data,
	input  kmsd_pkg::cmd_t           cmd,
	output kmsd_pkg::sts_t           sts,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_W-1:0]         m_tdata,
	output logic                     m_tlast
);
	import kmsd_pkg::*;

	localparam int PC_W     = $clog2(COLS + 1);
	localparam int ACC_RAW  = $clog2(ROWS * COLS + 1);
	localparam int ACC_W    = (ACC_RAW > KEY_W) ? ACC_RAW : KEY_W;
	localparam int OUT_BITS = 2 * RW + COLS + 1 + KEY_W;
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	logic [COLS-1:0]  raw_q [ROWS];
	logic [COLS-1:0]  stable_q [ROWS];
	logic [CNT_W-1:0] passes_q;
	logic [CNT_W-1:0] left_q;
	logic [RW-1:0]    ptr_q;
	logic [KEY_W-1:0] total_q;
	logic             m_tvalid_q;

	logic [COLS-1:0]  sample_q;
	logic [RW-1:0]    cur_row_q;
	logic             last_q;
	logic [RW-1:0]    sweep_q;
	logic [ACC_W-1:0] acc_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tlast_q;

	logic             changed;
	logic             is_last;
	logic [CNT_W-1:0] left_mid;
	logic [CNT_W-1:0] left_nxt;
	logic [RW-1:0]    ptr_nxt;
	logic [PC_W-1:0]  row_pop;
	logic [ACC_W-1:0] acc_sum;
	logic [OUT_BITS-1:0] out_bits;

	// Row update: a change reloads the counter before the pass end steps it.
	always_comb begin
		changed  = (raw_q[ptr_q] != sample_q);
		is_last  = (ptr_q == LAST_ROW);
		left_mid = changed ? passes_q : left_q;
		left_nxt = left_mid;
		if (is_last && (left_mid != '0)) begin
			left_nxt = left_mid - CNT_W'(1);
		end
		ptr_nxt  = is_last ? '0 : ptr_q + RW'(1);
	end

	always_comb begin
		row_pop = '0;
		for (int c = 0; c < COLS; c++) begin
			row_pop = row_pop + PC_W'(raw_q[sweep_q][c]);
		end
		acc_sum = acc_q + ACC_W'(row_pop);
	end

	assign sts.copy_needed = is_last && (left_mid == CNT_W'(1));
	assign sts.sweep_last  = (sweep_q == LAST_ROW);
	assign sts.out_free    = !m_tvalid_q || m_tready;

	assign out_bits = {ptr_q, total_q, (left_q == '0), stable_q[cur_row_q], cur_row_q};

	// Control state and the row stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				raw_q[i]    <= '0;
				stable_q[i] <= '0;
			end
			passes_q   <= PASSES_RESET;
			left_q     <= PASSES_RESET;
			ptr_q      <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				passes_q <= (cfg_data == '0) ? PASSES_RESET : cfg_data;
			end
			if (cmd.update) begin
				raw_q[ptr_q] <= sample_q;
				left_q       <= left_nxt;
				ptr_q        <= ptr_nxt;
			end
			if (cmd.copy_step) begin
				stable_q[sweep_q] <= raw_q[sweep_q];
				if (sts.sweep_last) begin
					total_q <= (acc_sum > ACC_W'(KEY_MAX)) ? KEY_MAX : KEY_W'(acc_sum);
				end
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= column_bits;
		end
		if (cmd.update) begin
			cur_row_q <= ptr_q;
			last_q    <= is_last;
			sweep_q   <= '0;
			acc_q     <= '0;
		end
		if (cmd.copy_step) begin
			sweep_q <= sweep_q + RW'(1);
			acc_q   <= acc_sum;
		end
		if (cmd.emit) begin
			m_tdata_q <= OUT_W'(out_bits);
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

/* design/key_matrix_scan_debounce.sv */
// Key matrix scanner with one shared debounce counter.
//
// Input stream (s_*): one word per sample, the column levels read while the row
// given by the previous result's next_row was driven. Output stream (m_*): one
// word per input word with the row index, its stable bits, the settled flag,
// the stable key count and the next row to drive; m_tlast marks the word that
// ended a full scan pass. The configuration channel (cfg_*) sets the number of
// change-free passes needed, a write of zero counts as one; write it only idle.
// A word is captured, then its row is updated, then the result register is
// loaded, and the next word is accepted in the cycle after that load.
// When a pass end brings the debounce counter to zero, the stable copy and key
// recount sweep one row per cycle between the row update and the result load.
// A finished result waits in the output register, so the
// next word is taken and processed while the receiver stalls; only its emission
// waits. Reset clears both row stores, the key count and the row pointer and
// loads the debounce setting and counter with one; cfg_ready is always high.
// Build with kmsd_pkg, kmsd_ctrl and kmsd_datapath.
`default_nettype none

module key_matrix_scan_debounce #(
	parameter int ROWS = kmsd_pkg::ROWS_DEF,
	parameter int COLS = kmsd_pkg::COLS_DEF,
	parameter int RW   = (ROWS > 1) ? $clog2(ROWS) : 1,
	parameter int IN_W = ((COLS + 7) / 8) * 8,
	parameter int OUT_W = ((2 * RW + COLS + 1 + kmsd_pkg::KEY_W + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// column_bits from bit 0; bits from COLS up are ignored
	input  logic [IN_W-1:0]            s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// row_index, stable_row, settled, key_count, next_row from bit 0; zero fill above
	output logic [OUT_W-1:0]           m_tdata,
	// pass_end
	output logic                       m_tlast,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	// debounce_passes
	input  logic [kmsd_pkg::CNT_W-1:0] cfg_data
);
	import kmsd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	kmsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kmsd_datapath #(
		.ROWS  (ROWS),
		.COLS  (COLS),
		.RW    (RW),
		.OUT_W (OUT_W)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.column_bits (s_tdata[COLS-1:0]),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

`ifndef SYNTHESIS
	// Only one word is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a word is still in work");

	// The next row follows the reported row, wrapping after a pass end.
	a_next_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast ? (m_tdata[2*RW+COLS+KEY_W:RW+COLS+1+KEY_W] == '0)
			: (m_tdata[2*RW+COLS+KEY_W:RW+COLS+1+KEY_W] == m_tdata[RW-1:0] + RW'(1))))
		else $error("next row does not follow the reported row");

	// Neither a copy step nor a row update is issued while a result is being emitted.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.copy_step && cmd.emit) && !(cmd.update && cmd.emit))
		else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

/* dv/key_matrix_scan_debounce_test.sv */
// Self-checking testbench for key_matrix_scan_debounce: feeds row samples under random
// stalls, predicts each result word from its own model of the scanner and compares them.
// Depends on kmsd_pkg and the key_matrix_scan_debounce RTL.
`default_nettype none

module key_matrix_scan_debounce_test;
	import kmsd_pkg::*;

	localparam int ROWS = ROWS_DEF;
	localparam int COLS = COLS_DEF;
	localparam int RW = $clog2(ROWS);
	localparam int IN_W = ((COLS + 7) / 8) * 8;
	localparam int OUT_W = ((2 * RW + COLS + 1 + KEY_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 3 + ROWS + 10;
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		logic [RW-1:0]    row_index;
		logic [COLS-1:0]  stable_row;
		logic             settled;
		logic [KEY_W-1:0] key_count;
		logic             pass_end;
		logic [RW-1:0]    next_row;
	} row_report_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	// Model of the scanner state.
	logic [COLS-1:0]  raw_mat [ROWS];
	logic [COLS-1:0]  stable_mat [ROWS];
	logic [CNT_W-1:0] passes_set;
	logic [CNT_W-1:0] quiet_left;
	logic [KEY_W-1:0] key_total;
	logic [RW-1:0]    scan_row;

	row_report_t     row_reports_due [$];
	logic [IN_W-1:0] pending_cols [$];
	logic [COLS-1:0] held_keys [ROWS];
	logic [RW-1:0]   gen_row = '0;

	logic in_taken = 1'b0;
	logic calm = 1'b0;
	logic last_stretch = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   cycles = 0;
	int   err_count = 0;
	int   samples_taken = 0;
	int   settle_events = 0;
	int   settings_used = 0;

	key_matrix_scan_debounce dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_count < PRINT_LIMIT)
			$display("ERROR t=%0t %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		err_count++;
	endtask

	function automatic void clear_scanner();
		for (int i = 0; i < ROWS; i++) begin
			raw_mat[i] = '0;
			stable_mat[i] = '0;
		end
		passes_set = PASSES_RESET;
		quiet_left = PASSES_RESET;
		key_total = '0;
		scan_row = '0;
	endfunction

	// Advances the scanner by one row sample and returns the word it reports.
	function automatic row_report_t scan_sample(input logic [IN_W-1:0] word);
		row_report_t rep;
		logic [COLS-1:0] cols;
		logic pass_done;
		int total;
		cols = word[COLS-1:0];
		total = 0;
		if (raw_mat[scan_row] != cols) begin
			raw_mat[scan_row] = cols;
			quiet_left = passes_set;
		end
		// A change in the last row reloads the counter before this pass end steps it.
		pass_done = (scan_row == RW'(ROWS - 1));
		if (pass_done && quiet_left != 0) begin
			quiet_left = quiet_left - 1'b1;
			if (quiet_left == 0) begin
				for (int i = 0; i < ROWS; i++) begin
					stable_mat[i] = raw_mat[i];
					for (int c = 0; c < COLS; c++)
						total += raw_mat[i][c];
				end
				key_total = (total > 255) ? KEY_W'(255) : KEY_W'(total);
				settle_events++;
			end
		end
		rep.row_index = scan_row;
		rep.stable_row = stable_mat[scan_row];
		rep.settled = (quiet_left == 0);
		rep.key_count = key_total;
		rep.pass_end = pass_done;
		rep.next_row = pass_done ? '0 : scan_row + 1'b1;
		scan_row = rep.next_row;
		return rep;
	endfunction

	// Sender: holds each word until taken, with random gaps between words.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_cols.size() > 0) begin
				if (!calm && !last_stretch && $urandom_range(0, 4) == 0) begin
					s_tvalid <= 1'b0;
					send_gap <= $urandom_range(0, 12);
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_cols.pop_front();
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts on m_tready.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && !last_stretch && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 12);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: checks each result word, then predicts for a newly taken sample.
	always @(posedge clk) begin
		row_report_t want;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (row_reports_due.size() == 0) begin
					report_mismatch("result word with nothing pending", int'(m_tdata), 0);
				end else begin
					want = row_reports_due.pop_front();
					if (m_tdata[RW-1:0] != want.row_index)
						report_mismatch("row_index", m_tdata[RW-1:0], want.row_index);
					if (m_tdata[RW +: COLS] != want.stable_row)
						report_mismatch("stable_row", m_tdata[RW +: COLS], want.stable_row);
					if (m_tdata[RW + COLS] != want.settled)
						report_mismatch("settled", m_tdata[RW + COLS], want.settled);
					if (m_tdata[RW + COLS + 1 +: KEY_W] != want.key_count)
						report_mismatch("key_count", m_tdata[RW + COLS + 1 +: KEY_W],
							want.key_count);
					if (m_tlast != want.pass_end)
						report_mismatch("pass_end", m_tlast, want.pass_end);
					if (m_tdata[RW + COLS + 1 + KEY_W +: RW] != want.next_row)
						report_mismatch("next_row", m_tdata[RW + COLS + 1 + KEY_W +: RW],
							want.next_row);
				end
			end
			if (s_tvalid && s_tready) begin
				row_reports_due.push_back(scan_sample(s_tdata));
				samples_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if ($urandom_range(0, 149) == 0)
			calm <= !calm;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// Waits until every pending word is out and answered, then lets the design settle.
	task automatic wait_drained();
		@(posedge clk);
		while (pending_cols.size() != 0 || s_tvalid || row_reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_passes(input logic [CNT_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		// A zero setting is kept as one.
		passes_set = (value == 0) ? CNT_W'(1) : value;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Scan passes over a held key pattern that changes now and then, with
	// contact bounce and some fully random samples mixed in.
	task automatic queue_scan_passes(input int n_items, input int change_pct,
		input int bounce_pct, input int noise_pct);
		int r;
		int p;
		logic [COLS-1:0] word;
		for (int k = 0; k < n_items; k++) begin
			if (gen_row == 0 && $urandom_range(0, 99) < change_pct) begin
				r = $urandom_range(0, ROWS - 1);
				case ($urandom_range(0, 3))
					0: held_keys[r] = COLS'($urandom());
					1: held_keys[r] = held_keys[r] ^ (COLS'(1) << $urandom_range(0, COLS - 1));
					2: held_keys[r] = '0;
					default: held_keys[r] = '1;
				endcase
			end
			word = held_keys[gen_row];
			p = $urandom_range(0, 99);
			if (p < noise_pct)
				word = COLS'($urandom());
			else if (p < noise_pct + bounce_pct)
				word = word ^ (COLS'(1) << $urandom_range(0, COLS - 1));
			pending_cols.push_back(IN_W'(word));
			gen_row = gen_row + 1'b1;
		end
	endtask

	initial begin
		clear_scanner();
		for (int i = 0; i < ROWS; i++)
			held_keys[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a full matrix, then assorted row patterns, then the same
		// patterns with only the last row changed.
		for (int i = 0; i < ROWS; i++)
			pending_cols.push_back('1);
		pending_cols.push_back(16'h0000);
		pending_cols.push_back(16'h8000);
		pending_cols.push_back(16'h0001);
		pending_cols.push_back(16'hAAAA);
		pending_cols.push_back(16'h5555);
		pending_cols.push_back(16'h00FF);
		pending_cols.push_back(16'hFF00);
		pending_cols.push_back(16'h1234);
		pending_cols.push_back(16'h0000);
		pending_cols.push_back(16'h8000);
		pending_cols.push_back(16'h0001);
		pending_cols.push_back(16'hAAAA);
		pending_cols.push_back(16'h5555);
		pending_cols.push_back(16'h00FF);
		pending_cols.push_back(16'hFF00);
		pending_cols.push_back(16'hEDCB);
		gen_row = RW'(24 % ROWS);
		for (int i = 0; i < ROWS; i++)
			held_keys[i] = '0;

		write_passes('0);
		queue_scan_passes(200, 25, 3, 2);
		write_passes(8'd2);
		queue_scan_passes(250, 20, 2, 2);
		write_passes('1);
		queue_scan_passes(60, 30, 5, 5);
		write_passes(8'd3);
		queue_scan_passes(250, 15, 2, 1);
		write_passes(CNT_W'($urandom_range(1, 6)));
		queue_scan_passes(250, 20, 3, 2);
		write_passes(8'd1);
		queue_scan_passes(200, 40, 10, 20);
		write_passes(8'd4);
		last_stretch = 1'b1;
		queue_scan_passes(200, 12, 2, 1);

		wait_drained();
		if (row_reports_due.size() != 0)
			report_mismatch("results never delivered", row_reports_due.size(), 0);
		$display("Covered %0d row samples under %0d debounce settings written after reset,",
			samples_taken, settings_used);
		$display("including %0d matrix settles and full, empty and single-key rows.",
			settle_events);
		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
